[rtl/tlf_pkg.sv]
// Shared types, constants and helpers for the tree leaf finder.
`default_nettype none

package tlf_pkg;

  // Sizing of the stores.
  localparam int NODES      = 1024;
  localparam int FEATURES   = 64;
  localparam int VALUE_BITS = 16;
  localparam int COUNT_BITS = 20;

  // Fixed field widths of the transfer payloads.
  localparam int CMD_W   = 3;
  localparam int NODE_W  = 10;
  localparam int FEAT_W  = 6;
  localparam int FVAL_W  = 16;
  localparam int TOTAL_W = 20;

  // Derived widths.
  localparam int NIDX_W = $clog2(NODES);
  localparam int FIDX_W = $clog2(FEATURES);
  localparam int STEP_W = $clog2(NODES + 1);

  // Derived constants.
  localparam logic [STEP_W-1:0]     STEP_LIMIT = STEP_W'(NODES);
  localparam logic [STEP_W-1:0]     STEP_ONE   = STEP_W'(1);
  localparam logic [NODE_W-1:0]     RANK_SAT   = NODE_W'(NODES - 1);
  localparam logic [NIDX_W-1:0]     CLR_LAST   = NIDX_W'(NODES - 1);
  localparam logic [NIDX_W-1:0]     CLR_ONE    = NIDX_W'(1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX    = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE    = COUNT_BITS'(1);

  // Status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_RUNAWAY = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR_TREE   = 3'd0,
    CMD_WRITE_NODE   = 3'd1,
    CMD_WRITE_FEAT   = 3'd2,
    CMD_CLASSIFY     = 3'd3,
    CMD_READ_COUNT   = 3'd4,
    CMD_CLEAR_COUNTS = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [NODE_W-1:0] node_index;
    logic [FEAT_W-1:0] split_feature;
    logic [FVAL_W-1:0] split_value;
    logic [NODE_W-1:0] left_child;
    logic [NODE_W-1:0] right_child;
    logic              is_leaf;
    logic [FEAT_W-1:0] feature_index;
    logic [FVAL_W-1:0] feature_value;
    logic [NODE_W-1:0] leaf_select;
    logic              count_it;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0]  leaf_node;
    logic [NODE_W-1:0]  leaf_rank;
    logic [TOTAL_W-1:0] leaf_total;
    logic               status;
  } out_item_t;

  // One node table word; the leaf ordinal lives beside the node fields.
  typedef struct packed {
    logic                  leaf;
    logic [NODE_W-1:0]     right;
    logic [NODE_W-1:0]     left;
    logic [VALUE_BITS-1:0] cut;
    logic [FEAT_W-1:0]     feat;
    logic [NODE_W-1:0]     rank;
  } node_word_t;

  localparam int NODE_WORD_W = $bits(node_word_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic tree_clr;
    logic node_wr;
    logic feat_wr;
    logic root_rd;
    logic feat_rd;
    logic child_rd;
    logic cnt_rd_leaf;
    logic cnt_rd_sel;
    logic cnt_done;
    logic fault;
    logic sel_zero;
    logic clr_start;
    logic clr_step;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic hit;
    logic limit;
    logic next_bad;
    logic sel_ok;
    logic clr_last;
    logic out_free;
  } dp_sts_t;

  function automatic logic [TOTAL_W-1:0] fit_total(input logic [COUNT_BITS-1:0] cnt);
    return TOTAL_W'(cnt);
  endfunction

  function automatic logic [VALUE_BITS-1:0] fit_value(input logic [FVAL_W-1:0] v);
    return VALUE_BITS'(v);
  endfunction

endpackage

`default_nettype wire

[rtl/tree_leaf_finder_with_leaf_counts.sv]
// Top level of the decision tree leaf finder with per-leaf hit counts.
`default_nettype none

// The block holds one binary decision tree of up to 1024 nodes, a vector of
// 64 features and a saturating hit count for every leaf ordinal. Every command
// is one transfer on the input channel; classify and read count each produce
// exactly one transfer on the result channel, the other commands none. It
// works on one command at a time. A write or a tree clear is decoded and done
// before the next command can be taken. A classify walks each tree level
// through a node state and a feature state, because each level reads the node
// memory and then the feature memory through their registered read ports; on a
// leaf it reads the count memory before the result goes to the output register.
// Read count reads the count memory in the same way. Clear counts sweeps the
// count memory one entry per cycle, and right after reset the same sweep runs
// while the input channel holds ready low. A finished result waits in an
// output register, so the block goes on taking commands while the result
// channel is stalled; it stalls only when a second result is ready before the
// first has been taken.

module tree_leaf_finder_with_leaf_counts (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tlf_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tlf_pkg::out_item_t      out_data
);

  // Command and status buses between the controller and the datapath.
  tlf_pkg::dp_cmd_t dp_cmd;
  tlf_pkg::dp_sts_t dp_sts;

  // The controller decides each cycle which memory port to use; it never
  // looks at the payload itself, only at the decoded status.
  tlf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (dp_sts),
    .c        (dp_cmd)
  );

  // The datapath holds the three memories, the walk registers, the running
  // leaf count and the output register of the result channel.
  tlf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .c         (dp_cmd),
    .sts       (dp_sts)
  );

endmodule

`default_nettype wire

[rtl/tlf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/tlf_dp.sv]
// Datapath: node, feature and count memories, walk registers and result registers.
`default_nettype none

module tlf_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tlf_pkg::in_item_t  in_data,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output tlf_pkg::out_item_t      out_data,
  input  wire tlf_pkg::dp_cmd_t   c,
  output tlf_pkg::dp_sts_t        sts
);

  tlf_pkg::in_item_t  item_r, item_nxt;
  tlf_pkg::out_item_t res_r, res_nxt;
  tlf_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [tlf_pkg::NODE_W-1:0] k_r, k_nxt;
  logic [tlf_pkg::STEP_W-1:0] steps_r, steps_nxt;
  logic                       first_r, first_nxt;
  logic                       feat_ok_r, feat_ok_nxt;
  logic [tlf_pkg::STEP_W-1:0] leaves_r, leaves_nxt;
  logic [tlf_pkg::NIDX_W-1:0] clr_r, clr_nxt;

  // Memory ports.
  logic                             node_we, node_re;
  logic [tlf_pkg::NIDX_W-1:0]       node_waddr, node_raddr;
  tlf_pkg::node_word_t              node_wdata, node_q;
  logic [tlf_pkg::NODE_WORD_W-1:0]  node_rdata;

  logic                             feat_we, feat_re;
  logic [tlf_pkg::FIDX_W-1:0]       feat_waddr, feat_raddr;
  logic [tlf_pkg::VALUE_BITS-1:0]   feat_wdata, feat_rdata;

  logic                             cnt_we, cnt_re;
  logic [tlf_pkg::NIDX_W-1:0]       cnt_waddr, cnt_raddr;
  logic [tlf_pkg::COUNT_BITS-1:0]   cnt_wdata, cnt_rdata;

  // Walk and count arithmetic.
  logic [tlf_pkg::VALUE_BITS-1:0]   fv;
  logic [tlf_pkg::NODE_W-1:0]       child;
  logic [tlf_pkg::COUNT_BITS-1:0]   cnt_inc;
  logic                             node_in_range;
  logic                             bump;
  logic [tlf_pkg::NODE_W-1:0]       new_rank;

  assign node_q = node_rdata;

  always_comb begin
    fv            = feat_ok_r ? feat_rdata : '0;
    child         = (fv > node_q.cut) ? node_q.right : node_q.left;
    cnt_inc       = (cnt_rdata != tlf_pkg::CNT_MAX) ? cnt_rdata + tlf_pkg::CNT_ONE : cnt_rdata;
    node_in_range = 32'(item_r.node_index) < tlf_pkg::NODES;
    bump          = (item_r.cmd == tlf_pkg::CMD_CLASSIFY) && item_r.count_it;
    if (!item_r.is_leaf) begin
      new_rank = '0;
    end else if (leaves_r < tlf_pkg::STEP_LIMIT) begin
      new_rank = tlf_pkg::NODE_W'(leaves_r);
    end else begin
      new_rank = tlf_pkg::RANK_SAT;
    end
  end

  // Node memory.
  always_comb begin
    node_we          = c.node_wr && node_in_range;
    node_waddr       = item_r.node_index[tlf_pkg::NIDX_W-1:0];
    node_wdata.leaf  = item_r.is_leaf;
    node_wdata.right = item_r.right_child;
    node_wdata.left  = item_r.left_child;
    node_wdata.cut   = tlf_pkg::fit_value(item_r.split_value);
    node_wdata.feat  = item_r.split_feature;
    node_wdata.rank  = new_rank;
    node_re          = c.root_rd || c.child_rd;
    node_raddr       = c.root_rd ? '0 : child[tlf_pkg::NIDX_W-1:0];
  end

  // Feature memory.
  always_comb begin
    feat_we    = c.feat_wr && (32'(item_r.feature_index) < tlf_pkg::FEATURES);
    feat_waddr = item_r.feature_index[tlf_pkg::FIDX_W-1:0];
    feat_wdata = tlf_pkg::fit_value(item_r.feature_value);
    feat_re    = c.feat_rd;
    feat_raddr = node_q.feat[tlf_pkg::FIDX_W-1:0];
  end

  // Count memory: the clearing sweep and the classify update share the write port.
  always_comb begin
    cnt_re    = c.cnt_rd_leaf || c.cnt_rd_sel;
    cnt_raddr = c.cnt_rd_leaf ? node_q.rank[tlf_pkg::NIDX_W-1:0]
                              : item_r.leaf_select[tlf_pkg::NIDX_W-1:0];
    cnt_we    = c.clr_step || (c.cnt_done && bump);
    cnt_waddr = c.clr_step ? clr_r : node_q.rank[tlf_pkg::NIDX_W-1:0];
    cnt_wdata = c.clr_step ? '0 : cnt_inc;
  end

  tlf_ram #(.WIDTH(tlf_pkg::NODE_WORD_W), .DEPTH(tlf_pkg::NODES)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .re(node_re), .raddr(node_raddr), .rdata(node_rdata)
  );

  tlf_ram #(.WIDTH(tlf_pkg::VALUE_BITS), .DEPTH(tlf_pkg::FEATURES)) u_feat_ram (
    .clk(clk), .we(feat_we), .waddr(feat_waddr), .wdata(feat_wdata),
    .re(feat_re), .raddr(feat_raddr), .rdata(feat_rdata)
  );

  tlf_ram #(.WIDTH(tlf_pkg::COUNT_BITS), .DEPTH(tlf_pkg::NODES)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  // Next values of the registers.
  always_comb begin
    item_nxt      = c.take ? in_data : item_r;
    k_nxt         = k_r;
    steps_nxt     = steps_r;
    first_nxt     = first_r;
    feat_ok_nxt   = feat_ok_r;
    leaves_nxt    = leaves_r;
    clr_nxt       = clr_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (c.root_rd) begin
      k_nxt     = '0;
      steps_nxt = '0;
      first_nxt = 1'b1;
    end
    if (c.feat_rd) begin
      feat_ok_nxt = 32'(node_q.feat) < tlf_pkg::FEATURES;
    end
    if (c.child_rd) begin
      k_nxt     = child;
      steps_nxt = steps_r + tlf_pkg::STEP_ONE;
      first_nxt = 1'b0;
    end

    if (c.tree_clr) begin
      leaves_nxt = '0;
    end else if (node_we && item_r.is_leaf && (leaves_r < tlf_pkg::STEP_LIMIT)) begin
      leaves_nxt = leaves_r + tlf_pkg::STEP_ONE;
    end

    if (c.clr_start) begin
      clr_nxt = '0;
    end else if (c.clr_step) begin
      clr_nxt = clr_r + tlf_pkg::CLR_ONE;
    end

    if (c.fault) begin
      res_nxt.leaf_node  = '0;
      res_nxt.leaf_rank  = '0;
      res_nxt.leaf_total = '0;
      res_nxt.status     = tlf_pkg::STATUS_RUNAWAY;
    end else if (c.sel_zero) begin
      res_nxt.leaf_node  = '0;
      res_nxt.leaf_rank  = item_r.leaf_select;
      res_nxt.leaf_total = '0;
      res_nxt.status     = tlf_pkg::STATUS_OK;
    end else if (c.cnt_done) begin
      if (item_r.cmd == tlf_pkg::CMD_CLASSIFY) begin
        res_nxt.leaf_node  = k_r;
        res_nxt.leaf_rank  = node_q.rank;
        res_nxt.leaf_total = tlf_pkg::fit_total(bump ? cnt_inc : cnt_rdata);
      end else begin
        res_nxt.leaf_node  = '0;
        res_nxt.leaf_rank  = item_r.leaf_select;
        res_nxt.leaf_total = tlf_pkg::fit_total(cnt_rdata);
      end
      res_nxt.status = tlf_pkg::STATUS_OK;
    end

    if (c.out_load) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      leaves_r    <= '0;
      clr_r       <= '0;
      first_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      leaves_r    <= leaves_nxt;
      clr_r       <= clr_nxt;
      first_r     <= first_nxt;
    end
    item_r    <= item_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
    k_r       <= k_nxt;
    steps_r   <= steps_nxt;
    feat_ok_r <= feat_ok_nxt;
  end

  always_comb begin
    sts.cmd      = tlf_pkg::cmd_t'(item_r.cmd);
    sts.hit      = !first_r && node_q.leaf;
    sts.limit    = steps_r == tlf_pkg::STEP_LIMIT;
    sts.next_bad = !(32'(child) < tlf_pkg::NODES);
    sts.sel_ok   = 32'(item_r.leaf_select) < tlf_pkg::NODES;
    sts.clr_last = clr_r == tlf_pkg::CLR_LAST;
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

[rtl/tlf_ctrl.sv]
// Controller: sequences commands, tree walks, count updates and clearing sweeps.
`default_nettype none

module tlf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tlf_pkg::dp_sts_t  sts,
  output tlf_pkg::dp_cmd_t       c
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_DECODE,
    S_NODE,
    S_FEAT,
    S_CNT,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    c         = '0;
    case (state_r)
      S_CLR: begin
        c.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        c.take = in_valid;
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        case (sts.cmd)
          tlf_pkg::CMD_CLEAR_TREE: begin
            c.tree_clr = 1'b1;
          end
          tlf_pkg::CMD_WRITE_NODE: begin
            c.node_wr = 1'b1;
          end
          tlf_pkg::CMD_WRITE_FEAT: begin
            c.feat_wr = 1'b1;
          end
          tlf_pkg::CMD_CLASSIFY: begin
            c.root_rd = 1'b1;
            state_nxt = S_NODE;
          end
          tlf_pkg::CMD_READ_COUNT: begin
            if (sts.sel_ok) begin
              c.cnt_rd_sel = 1'b1;
              state_nxt    = S_CNT;
            end else begin
              c.sel_zero = 1'b1;
              state_nxt  = S_OUT;
            end
          end
          tlf_pkg::CMD_CLEAR_COUNTS: begin
            c.clr_start = 1'b1;
            state_nxt   = S_CLR;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_NODE: begin
        if (sts.hit) begin
          c.cnt_rd_leaf = 1'b1;
          state_nxt     = S_CNT;
        end else if (sts.limit) begin
          c.fault   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          c.feat_rd = 1'b1;
          state_nxt = S_FEAT;
        end
      end
      S_FEAT: begin
        if (sts.next_bad) begin
          c.fault   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          c.child_rd = 1'b1;
          state_nxt  = S_NODE;
        end
      end
      S_CNT: begin
        c.cnt_done = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          c.out_load = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

endmodule

`default_nettype wire

[rtl/tlf_checker.sv]
// Port-level checks for the tree leaf finder and their binding to the top level.
`default_nettype none

module tlf_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire tlf_pkg::out_item_t out_data
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // A runaway walk reports nothing but its status.
  a_runaway_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == tlf_pkg::STATUS_RUNAWAY) |->
      (out_data.leaf_node == '0) && (out_data.leaf_rank == '0) &&
      (out_data.leaf_total == '0))
    else $error("runaway result carries a leaf or a count");

  // Commands are handled one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while one is in work");

  // The count clearing sweep after reset holds off commands.
  a_reset_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready)
    else $error("command taken before the count memory was cleared");

endmodule

bind tree_leaf_finder_with_leaf_counts tlf_checker u_tlf_checker (.*);

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the decision tree leaf finder with per-leaf hit counts.
`timescale 1ns / 100ps

// The testbench first walks a short table of directed commands, then fills every node and
// feature entry once, which also runs the leaf ordinal past its saturation point. After that
// it plays random episodes: each episode clears the tree, writes a small tree in ascending
// node order, and then mixes classifies, feature writes, count reads, count clears and a
// little noise. Every command transfer that is accepted runs through a predictor of the
// block. The predictor holds its own copy of the tree, the features and the hit counts.
// Each result transfer is compared field by field with the oldest answer still due.

module testbench;
  import tlf_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int RANDOM_ITEMS   = 750;
  // The slowest wait between two transfers is a runaway walk of 1024 levels plus both
  // stalls. The limit leaves a wide margin.
  localparam int IDLE_LIMIT     = 10000;
  // A clear counts sweep produces no result, so the final wait must outlast one sweep
  // before the run can end.
  localparam int DRAIN_CYCLES   = 1200;
  localparam int IN_W           = $bits(in_item_t);

  // The two command codes that the block ignores.
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  // One tree node as the predictor keeps it.
  typedef struct packed {
    logic                  leaf;
    logic [NODE_W-1:0]     right;
    logic [NODE_W-1:0]     left;
    logic [VALUE_BITS-1:0] cut;
    logic [FEAT_W-1:0]     feat;
  } tree_entry_t;

  // One row of the directed table. The answer is used only where typed is set.
  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t want;
  } script_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Predictor state.
  tree_entry_t           tree_mem    [NODES];
  logic [NODE_W-1:0]     ordinal_mem [NODES];
  logic [VALUE_BITS-1:0] feature_mem [FEATURES];
  logic [COUNT_BITS-1:0] hit_count   [NODES];
  int unsigned           leaf_tally;

  out_item_t answers_due [$];
  int        mismatches   = 0;
  int        random_items = 0;
  int        idle_cycles  = 0;
  int        in_calm      = 0;
  int        out_calm     = 0;

  tree_leaf_finder_with_leaf_counts dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Directed table. Columns of the command: cmd, node index, split feature, cut, left child,
  // right child, leaf bit, feature index, feature value, leaf select, count enable.
  script_row_t script_rows [24] = '{
    // Right after the reset sweep every count reads zero, at both ends of the select range.
    '{'{CMD_READ_COUNT, 10'd0, 6'd0, 16'h0000, 10'd0, 10'd0, 1'b0, 6'd0, 16'h0000, 10'd0, 1'b0},
      1'b1, '{10'd0, 10'd0, 20'd0, STATUS_OK}},
    '{'{CMD_READ_COUNT, 10'd0, 6'd0, 16'h0000, 10'd0, 10'd0, 1'b0, 6'd0, 16'h0000, 10'd1023,
      1'b0}, 1'b1, '{10'd0, 10'd1023, 20'd0, STATUS_OK}},
    // Both unknown codes are dropped without a result, once with all fields low, once high.
    '{'{CMD_SPARE_6, 10'd0, 6'd0, 16'h0000, 10'd0, 10'd0, 1'b0, 6'd0, 16'h0000, 10'd0, 1'b0},
      1'b0, '0},
    '{'{CMD_SPARE_7, 10'h3FF, 6'h3F, 16'hFFFF, 10'h3FF, 10'h3FF, 1'b1, 6'h3F, 16'hFFFF, 10'h3FF,
      1'b1}, 1'b0, '0},
    '{'{CMD_CLEAR_TREE, 10'd0, 6'd0, 16'h0000, 10'd0, 10'd0, 1'b0, 6'd0, 16'h0000, 10'd0, 1'b0},
      1'b0, '0},
    '{'{CMD_WRITE_FEAT, 10'd0, 6'd0, 16'h0000, 10'd0, 10'd0, 1'b0, 6'd0, 16'h0000, 10'd0, 1'b0},
      1'b0, '0},
    '{'{CMD_WRITE_FEAT, 10'd0, 6'd0, 16'h0000, 10'd0, 10'd0, 1'b0, 6'd63, 16'hFFFF, 10'd0, 1'b0},
      1'b0, '0},
    '{'{CMD_WRITE_FEAT, 10'd0, 6'd0, 16'h0000, 10'd0, 10'd0, 1'b0, 6'd1, 16'd1234, 10'd0, 1'b0},
      1'b0, '0},
    // Root tests the top feature slot against a cut one below the largest value.
    '{'{CMD_WRITE_NODE, 10'd0, 6'd63, 16'hFFFE, 10'd1, 10'd1023, 1'b0, 6'd0, 16'h0000, 10'd0,
      1'b0}, 1'b0, '0},
    '{'{CMD_WRITE_NODE, 10'd1, 6'd0, 16'h0000, 10'd0, 10'd0, 1'b1, 6'd0, 16'h0000, 10'd0, 1'b0},
      1'b0, '0},
    '{'{CMD_WRITE_NODE, 10'd1023, 6'd0, 16'h0000, 10'd0, 10'd0, 1'b1, 6'd0, 16'h0000, 10'd0,
      1'b0}, 1'b0, '0},
    // The largest value is above the cut, so the walk goes right to the top node.
    '{'{CMD_CLASSIFY, 10'd0, 6'd0, 16'h0000, 10'd0, 10'd0, 1'b0, 6'd0, 16'h0000, 10'd0, 1'b1},
      1'b1, '{10'd1023, 10'd1, 20'd1, STATUS_OK}},
    // Without the count enable the total stays where it was.
    '{'{CMD_CLASSIFY, 10'd0, 6'd0, 16'h0000, 10'd0, 10'd0, 1'b0, 6'd0, 16'h0000, 10'd0, 1'b0},
      1'b1, '{10'd1023, 10'd1, 20'd1, STATUS_OK}},
    '{'{CMD_WRITE_FEAT, 10'd0, 6'd0, 16'h0000, 10'd0, 10'd0, 1'b0, 6'd63, 16'h0000, 10'd0, 1'b0},
      1'b0, '0},
    '{'{CMD_CLASSIFY, 10'd0, 6'd0, 16'h0000, 10'd0, 10'd0, 1'b0, 6'd0, 16'h0000, 10'd0, 1'b1},
      1'b1, '{10'd1, 10'd0, 20'd1, STATUS_OK}},
    '{'{CMD_READ_COUNT, 10'd0, 6'd0, 16'h0000, 10'd0, 10'd0, 1'b0, 6'd0, 16'h0000, 10'd1, 1'b0},
      1'b1, '{10'd0, 10'd1, 20'd1, STATUS_OK}},
    '{'{CMD_CLEAR_COUNTS, 10'd0, 6'd0, 16'h0000, 10'd0, 10'd0, 1'b0, 6'd0, 16'h0000, 10'd0,
      1'b0}, 1'b0, '0},
    '{'{CMD_READ_COUNT, 10'd0, 6'd0, 16'h0000, 10'd0, 10'd0, 1'b0, 6'd0, 16'h0000, 10'd1, 1'b0},
      1'b1, '{10'd0, 10'd1, 20'd0, STATUS_OK}},
    // A tree clear only restarts the leaf ordinals; the old nodes stay in place.
    '{'{CMD_CLEAR_TREE, 10'd0, 6'd0, 16'h0000, 10'd0, 10'd0, 1'b0, 6'd0, 16'h0000, 10'd0, 1'b0},
      1'b0, '0},
    // A root that points back at itself never reaches a leaf: runaway walk.
    '{'{CMD_WRITE_NODE, 10'd0, 6'd1, 16'h0000, 10'd0, 10'd0, 1'b0, 6'd0, 16'h0000, 10'd0, 1'b0},
      1'b0, '0},
    '{'{CMD_CLASSIFY, 10'd0, 6'd0, 16'h0000, 10'd0, 10'd0, 1'b0, 6'd0, 16'h0000, 10'd0, 1'b1},
      1'b1, '{10'd0, 10'd0, 20'd0, STATUS_RUNAWAY}},
    // A root that is a leaf itself still takes one step, here down to an old leaf.
    '{'{CMD_WRITE_NODE, 10'd0, 6'd1, 16'hFFFF, 10'd1, 10'd0, 1'b1, 6'd0, 16'h0000, 10'd0, 1'b0},
      1'b0, '0},
    '{'{CMD_CLASSIFY, 10'd0, 6'd0, 16'h0000, 10'd0, 10'd0, 1'b0, 6'd0, 16'h0000, 10'd0, 1'b1},
      1'b0, '0},
    '{'{CMD_READ_COUNT, 10'd0, 6'd0, 16'h0000, 10'd0, 10'd0, 1'b0, 6'd0, 16'h0000, 10'd0, 1'b0},
      1'b0, '0}
  };

  // Works out what one accepted command does to the block and which result, if any, it owes.
  function automatic void tree_answer(input in_item_t w, output bit has, output out_item_t ans);
    tree_entry_t           cur;
    logic [NODE_W-1:0]     here;
    logic [NODE_W-1:0]     slot;
    int                    hops;
    bit                    landed;
    has = 1'b0;
    ans = '0;
    case (w.cmd)
      CMD_CLEAR_TREE: begin
        leaf_tally = 0;
      end
      CMD_WRITE_NODE: begin
        tree_mem[w.node_index] = '{leaf: w.is_leaf, right: w.right_child, left: w.left_child,
                                   cut: w.split_value, feat: w.split_feature};
        if (w.is_leaf) begin
          // Once every ordinal is used up, further leaves share the last one.
          ordinal_mem[w.node_index] = (leaf_tally < NODES) ? NODE_W'(leaf_tally)
                                                           : NODE_W'(NODES - 1);
          if (leaf_tally < NODES) leaf_tally++;
        end else begin
          ordinal_mem[w.node_index] = '0;
        end
      end
      CMD_WRITE_FEAT: begin
        feature_mem[w.feature_index] = w.feature_value;
      end
      CMD_CLASSIFY: begin
        has    = 1'b1;
        here   = '0;
        hops   = 0;
        landed = 1'b0;
        // Child indices are ten bits wide, so with 1024 nodes the step limit is the only
        // way for a walk to fail.
        while (hops < NODES && !landed) begin
          cur    = tree_mem[here];
          here   = (feature_mem[cur.feat] > cur.cut) ? cur.right : cur.left;
          hops++;
          landed = tree_mem[here].leaf;
        end
        if (!landed) begin
          ans.status = STATUS_RUNAWAY;
        end else begin
          slot = ordinal_mem[here];
          if (w.count_it && hit_count[slot] != '1) hit_count[slot]++;
          ans.leaf_node  = here;
          ans.leaf_rank  = ordinal_mem[here];
          ans.leaf_total = TOTAL_W'(hit_count[slot]);
          ans.status     = STATUS_OK;
        end
      end
      CMD_READ_COUNT: begin
        has            = 1'b1;
        ans.leaf_rank  = w.leaf_select;
        ans.leaf_total = TOTAL_W'(hit_count[w.leaf_select]);
        ans.status     = STATUS_OK;
      end
      CMD_CLEAR_COUNTS: begin
        foreach (hit_count[i]) hit_count[i] = '0;
      end
      default: begin
      end
    endcase
  endfunction

  // Idle cycles before the next transfer on one side. Now and then a calm stretch of
  // back-to-back transfers is forced.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // A command with every field random except the code.
  function automatic in_item_t junk(input logic [CMD_W-1:0] code);
    in_item_t w;
    w     = IN_W'({$urandom, $urandom, $urandom});
    w.cmd = code;
    return w;
  endfunction

  // Drives one command transfer. Valid is only lowered when a gap is drawn, so it is never
  // lowered and raised in the same time step. The prediction is made at the accepting edge.
  task automatic issue(input in_item_t w, input bit typed, input out_item_t typed_ans);
    int        gap;
    bit        has;
    out_item_t ans;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    tree_answer(w, has, ans);
    if (has) answers_due.push_back(typed ? typed_ans : ans);
  endtask

  task automatic send(input in_item_t w);
    issue(w, 1'b0, '0);
  endtask

  // Writes every feature slot and every node once, so that no later walk can touch an entry
  // that was never written. All nodes are leaves and two more leaves follow, which drives
  // the leaf ordinal into saturation.
  task automatic fill_all_stores();
    in_item_t w;
    int       i;
    for (i = 0; i < FEATURES; i++) begin
      w               = junk(CMD_WRITE_FEAT);
      w.feature_index = FEAT_W'(i);
      send(w);
    end
    send(junk(CMD_CLEAR_TREE));
    for (i = 0; i < NODES + 2; i++) begin
      w         = junk(CMD_WRITE_NODE);
      w.is_leaf = 1'b1;
      if (i < NODES) w.node_index = NODE_W'(i);
      send(w);
    end
    for (i = 0; i < 3; i++) send(junk(CMD_CLASSIFY));
    w             = junk(CMD_READ_COUNT);
    w.leaf_select = NODE_W'(NODES - 1);
    send(w);
  endtask

  // One episode: clear the tree, write a fresh tree over sorted node indices with root 0,
  // then use it. Internal nodes point only forward in index order, so the walk ends on a
  // leaf, except in the rare looping trees that are built to run away.
  task automatic run_episode();
    int unsigned           picks  [$];
    logic [FEAT_W-1:0]     tested [$];
    logic [VALUE_BITS-1:0] cuts   [$];
    bit                    taken  [int unsigned];
    int unsigned           cand;
    int                    n, p, m, r, k;
    bit                    loopy;
    in_item_t              w;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(3, 16);
    picks.push_back(0);
    taken[0] = 1'b1;
    while (picks.size() < n) begin
      cand = $urandom_range(1, NODES - 1);
      if (!taken.exists(cand)) begin
        taken[cand] = 1'b1;
        picks.push_back(cand);
      end
    end
    picks.sort();
    loopy = ($urandom_range(0, 19) == 0);
    send(junk(CMD_CLEAR_TREE));
    random_items++;

    for (p = 0; p < n; p++) begin
      w            = junk(CMD_WRITE_NODE);
      w.node_index = NODE_W'(picks[p]);
      w.is_leaf    = (p == n - 1) || ($urandom_range(0, 3) == 0);
      if (p < n - 1) begin
        // Half the time the next node in order is taken, which builds deep chains.
        w.left_child  = NODE_W'(picks[$urandom_range(0, 1) ? p + 1 : $urandom_range(p + 1, n - 1)]);
        w.right_child = NODE_W'(picks[$urandom_range(0, 1) ? p + 1 : $urandom_range(p + 1, n - 1)]);
      end
      if (loopy && p > 0 && $urandom_range(0, 2) == 0) begin
        w.right_child = NODE_W'(picks[$urandom_range(0, p)]);
      end
      if ($urandom_range(0, 7) == 0) w.split_value = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      tested.push_back(w.split_feature);
      cuts.push_back(w.split_value);
      send(w);
      random_items++;
    end

    m = $urandom_range(4, 14);
    for (k = 0; k < m; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        w = junk(CMD_CLASSIFY);
      end else if (r < 70) begin
        // Often the feature lands right on a cut or just above it.
        w = junk(CMD_WRITE_FEAT);
        p = $urandom_range(0, n - 1);
        case ($urandom_range(0, 3))
          0: begin
            w.feature_index = tested[p];
            w.feature_value = cuts[p];
          end
          1: begin
            w.feature_index = tested[p];
            w.feature_value = cuts[p] + 1'b1;
          end
          default: begin
          end
        endcase
      end else if (r < 85) begin
        w = junk(CMD_READ_COUNT);
        if ($urandom_range(0, 1)) w.leaf_select = NODE_W'($urandom_range(0, 40));
      end else if (r < 97) begin
        // Noise: ignored codes, a stray tree clear or a node write with random content.
        case ($urandom_range(0, 3))
          0:       w = junk(CMD_SPARE_6);
          1:       w = junk(CMD_SPARE_7);
          2:       w = junk(CMD_CLEAR_TREE);
          default: w = junk(CMD_WRITE_NODE);
        endcase
      end else begin
        w = junk(CMD_CLEAR_COUNTS);
      end
      send(w);
      if (w.cmd != CMD_SPARE_6 && w.cmd != CMD_SPARE_7) random_items++;
    end
  endtask

  task automatic flag_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatches++;
  endtask

  // Result receiver: draws a stall for every result, then holds ready until a transfer.
  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait(out_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Checks each result transfer against the oldest answer still due.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (answers_due.size() == 0) begin
        flag_mismatch($sformatf("result with nothing due: %h", out_data));
      end else begin
        want = answers_due.pop_front();
        if (out_data.leaf_node !== want.leaf_node)
          flag_mismatch($sformatf("leaf_node got %0d want %0d",
                                  out_data.leaf_node, want.leaf_node));
        if (out_data.leaf_rank !== want.leaf_rank)
          flag_mismatch($sformatf("leaf_rank got %0d want %0d",
                                  out_data.leaf_rank, want.leaf_rank));
        if (out_data.leaf_total !== want.leaf_total)
          flag_mismatch($sformatf("leaf_total got %0d want %0d",
                                  out_data.leaf_total, want.leaf_total));
        if (out_data.status !== want.status)
          flag_mismatch($sformatf("status got %0b want %0b", out_data.status, want.status));
      end
    end
  end

  // Watchdog: too many cycles in a row without any transfer means the block has hung.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Main sequence: reset, directed table, store fill, random episodes, drain.
  initial begin
    leaf_tally = 0;
    foreach (hit_count[i]) hit_count[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script_rows[i]) issue(script_rows[i].stim, script_rows[i].typed, script_rows[i].want);
    fill_all_stores();
    while (random_items < RANDOM_ITEMS) run_episode();
    in_valid <= 1'b0;

    // Wait for every answer, then long enough for a trailing sweep to show a stray result.
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
